/* design/lxr_pkg.sv */
package lxr_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BYTE   = 2'd0;
    localparam kind_t KIND_SCALED = 2'd1;
    localparam kind_t KIND_SEED   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REF_RD,
        ST_REF_WR,
        ST_DRAW
    } state_t;

endpackage

/* design/lxr_mem.sv */
module lxr_mem #(
    parameter int DEPTH  = 55,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [7:0]        rdata0,
    output logic [7:0]        rdata1
);

    logic [7:0] mem_q [DEPTH];
    logic [7:0] rdata0_reg;
    logic [7:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0_reg <= mem_q[raddr0];
        rdata1_reg <= mem_q[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

/* design/lagged_xor_byte_rng.sv */
// channel   direction  handshake          ports
// command   in         start & !busy      kind, scale_limit, seed_index, seed_value
// result    out        done, no stall     random_value
//
// a seed write or an unused kind leaves busy low
// a draw without a refill keeps busy high for one cycle; done and random_value follow in the next
// every TABLE_SIZE-th draw first refills the table: each entry is read with its partner
// (ST_REF_RD), then written back (ST_REF_WR); busy stays high throughout the refill
// reset sets the position to the last entry, so the first draw refills
// the table holds whatever was seeded; it has no reset
module lagged_xor_byte_rng #(
    parameter int TABLE_SIZE = 55,
    parameter int SHORT_LAG  = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] scale_limit,
    input  logic [5:0] seed_index,
    input  logic [7:0] seed_value,
    output logic       done,
    output logic [7:0] random_value
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int PW    = $clog2(TABLE_SIZE + SHORT_LAG) + 2;

    localparam logic signed [PW-1:0] LONG_S  = PW'(TABLE_SIZE - SHORT_LAG);
    localparam logic signed [PW-1:0] SHORT_S = PW'(SHORT_LAG);
    localparam logic signed [PW-1:0] SIZE_S  = PW'(TABLE_SIZE);
    localparam logic [IDX_W-1:0]     LAST    = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W:0]       SIZE_U  = (IDX_W + 1)'(TABLE_SIZE);

    lxr_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             scaled_reg, scaled_next;
    logic [7:0]       limit_reg, limit_next;
    logic             done_reg, done_next;
    logic [7:0]       value_reg, value_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr0;
    logic [IDX_W-1:0] raddr1;
    logic [7:0]       rdata0;
    logic [7:0]       rdata1;

    logic [IDX_W:0]          pos_plus;
    logic signed [PW-1:0]    idx_ext;
    logic signed [PW-1:0]    partner;
    logic                    partner_ok;
    logic                    seed_ok;
    logic [15:0]             product;

    lxr_mem #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign pos_plus = {1'b0, pos_reg} + (IDX_W + 1)'(1);
    assign idx_ext  = signed'({{(PW - IDX_W){1'b0}}, idx_reg});
    assign partner  = (int'(idx_reg) < SHORT_LAG) ? idx_ext + LONG_S : idx_ext - SHORT_S;
    assign partner_ok = !partner[PW-1] && (partner < SIZE_S);
    assign seed_ok  = int'(seed_index) < TABLE_SIZE;
    assign product  = limit_reg * rdata0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lxr_pkg::ST_IDLE;
            pos_reg    <= LAST;
            idx_reg    <= '0;
            scaled_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            scaled_reg <= scaled_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        scaled_next = scaled_reg;
        limit_next  = limit_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        we          = 1'b0;
        waddr       = IDX_W'(seed_index);
        wdata       = seed_value;
        raddr0      = pos_plus[IDX_W-1:0];
        raddr1      = partner[IDX_W-1:0];

        unique case (state_reg)
            lxr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind) inside
                        lxr_pkg::KIND_BYTE, lxr_pkg::KIND_SCALED:
                        begin
                            scaled_next = (kind == lxr_pkg::KIND_SCALED);
                            limit_next  = scale_limit;
                            if (pos_plus >= SIZE_U)
                            begin
                                idx_next   = '0;
                                state_next = lxr_pkg::ST_REF_RD;
                            end
                            else
                            begin
                                pos_next   = pos_plus[IDX_W-1:0];
                                state_next = lxr_pkg::ST_DRAW;
                            end
                        end
                        lxr_pkg::KIND_SEED:
                        begin
                            we = seed_ok;
                        end
                        default:
                        begin
                            we = 1'b0;
                        end
                    endcase
                end
            end
            lxr_pkg::ST_REF_RD:
            begin
                raddr0     = idx_reg;
                state_next = lxr_pkg::ST_REF_WR;
            end
            lxr_pkg::ST_REF_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = partner_ok ? (rdata0 ^ rdata1) : rdata0;
                if (idx_reg == LAST)
                begin
                    pos_next   = '0;
                    raddr0     = '0;
                    state_next = lxr_pkg::ST_DRAW;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = lxr_pkg::ST_REF_RD;
                end
            end
            lxr_pkg::ST_DRAW:
            begin
                value_next = scaled_reg ? product[15:8] : rdata0;
                done_next  = 1'b1;
                state_next = lxr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lxr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != lxr_pkg::ST_IDLE);
    assign done         = done_reg;
    assign random_value = value_reg;

    a_done_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == lxr_pkg::ST_DRAW)
        else $error("result without a draw");

    a_refill_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lxr_pkg::ST_REF_WR && idx_reg == LAST)
        |=> (state_reg == lxr_pkg::ST_DRAW && pos_reg == '0))
        else $error("refill end did not reset position");

    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == lxr_pkg::KIND_SEED) |=> (!busy && !done))
        else $error("seed write produced activity");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST)
        else $error("position out of range");

endmodule

/* tb/sv/lagged_xor_byte_rng_test.sv */
module lagged_xor_byte_rng_test;

    localparam int TBL_LEN = 55;
    localparam int LAG = 24;
    localparam lxr_pkg::kind_t KIND_UNUSED = 2'd3;

    typedef struct {
        lxr_pkg::kind_t kind;
        logic [7:0]     limit;
        logic [5:0]     index;
        logic [7:0]     value;
        int             gap;
        bit             drain;
    } rng_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] kind = lxr_pkg::KIND_BYTE;
    logic [7:0] scale_limit = 8'd0;
    logic [5:0] seed_index = 6'd0;
    logic [7:0] seed_value = 8'd0;
    logic       busy;
    logic       done;
    logic [7:0] random_value;

    rng_cmd_t   cmd_backlog[$];
    logic [7:0] expected_bytes[$];
    logic [7:0] shadow_table[TBL_LEN];
    int         shadow_pos = TBL_LEN - 1;
    int         err_count = 0;
    logic       cmd_taken = 1'b0;
    rng_cmd_t   cur_cmd;
    bit         cur_loaded = 1'b0;
    int         gap_left = 0;

    lagged_xor_byte_rng #(
        .TABLE_SIZE(TBL_LEN),
        .SHORT_LAG (LAG)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .scale_limit (scale_limit),
        .seed_index  (seed_index),
        .seed_value  (seed_value),
        .done        (done),
        .random_value(random_value)
    );

    always #10 clk = ~clk;

    // update the shadow table and position for one accepted item
    task automatic predict_item(input lxr_pkg::kind_t k, input logic [7:0] lim,
                                input logic [5:0] idx, input logic [7:0] val);
        logic [7:0]  drawn;
        logic [15:0] prod;
        int          nxt;
        int          partner;
        if (k == lxr_pkg::KIND_SEED)
        begin
            if (idx < TBL_LEN)
                shadow_table[idx] = val;
        end
        else if (k == lxr_pkg::KIND_BYTE || k == lxr_pkg::KIND_SCALED)
        begin
            nxt = shadow_pos + 1;
            if (nxt >= TBL_LEN)
            begin
                for (int i = 0; i < TBL_LEN; i++)
                begin
                    partner = (i < LAG) ? i + TBL_LEN - LAG : i - LAG;
                    if (partner < TBL_LEN)
                        shadow_table[i] = shadow_table[i] ^ shadow_table[partner];
                end
                nxt = 0;
            end
            shadow_pos = nxt;
            drawn = shadow_table[nxt];
            if (k == lxr_pkg::KIND_BYTE)
                expected_bytes.push_back(drawn);
            else
            begin
                prod = lim * drawn;
                expected_bytes.push_back(prod[15:8]);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_cmd(input lxr_pkg::kind_t k, input logic [7:0] lim,
                           input logic [5:0] idx, input logic [7:0] val,
                           input int gap, input bit drain);
        rng_cmd_t c;
        c.kind = k;
        c.limit = lim;
        c.index = idx;
        c.value = val;
        c.gap = gap;
        c.drain = drain;
        cmd_backlog.push_back(c);
    endtask

    // monitor: check results, then predict the item taken at this edge
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            cmd_taken <= start && !busy;
            if (done)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected result %0d at %0t", random_value, $realtime);
                    err_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (random_value !== want)
                    begin
                        if (err_count < 10)
                            $display("random_value mismatch: expected %0d, got %0d at %0t",
                                     want, random_value, $realtime);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
                predict_item(lxr_pkg::kind_t'(kind), scale_limit, seed_index, seed_value);
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic go;
        if (rst_n && !(start && !cmd_taken))
        begin
            go = 1'b0;
            if (!cur_loaded && cmd_backlog.size() > 0)
            begin
                cur_cmd = cmd_backlog.pop_front();
                cur_loaded = 1'b1;
                gap_left = cur_cmd.gap;
            end
            if (cur_loaded)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!(cur_cmd.drain && expected_bytes.size() != 0))
                begin
                    go = 1'b1;
                    kind <= cur_cmd.kind;
                    scale_limit <= cur_cmd.limit;
                    seed_index <= cur_cmd.index;
                    seed_value <= cur_cmd.value;
                    cur_loaded = 1'b0;
                end
            end
            start <= go;
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int r;
        bit no_idle;
        int g;
        lxr_pkg::kind_t k;
        for (int i = 0; i < TBL_LEN; i++)
            shadow_table[i] = 8'd0;

        // every entry is seeded before the first draw
        add_cmd(lxr_pkg::KIND_SEED, 8'hff, 6'd0, 8'hff, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SEED, 8'h00, 6'd54, 8'h00, 1, 1'b0);
        for (int i = 1; i < TBL_LEN - 1; i++)
            add_cmd(lxr_pkg::KIND_SEED, 8'($urandom_range(0, 255)), 6'(i),
                    8'($urandom_range(0, 255)), pick_gap(), 1'b0);

        // directed
        add_cmd(lxr_pkg::KIND_SEED, 8'h12, 6'd55, 8'h5a, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SEED, 8'hff, 6'd63, 8'hff, 0, 1'b0);
        add_cmd(KIND_UNUSED, 8'hff, 6'd63, 8'hff, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_BYTE, 8'h00, 6'd0, 8'h00, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_BYTE, 8'hff, 6'd63, 8'hff, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SCALED, 8'd0, 6'd0, 8'h00, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SCALED, 8'd255, 6'd0, 8'h00, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SCALED, 8'd1, 6'd0, 8'h00, 2, 1'b0);
        add_cmd(lxr_pkg::KIND_SCALED, 8'd128, 6'd0, 8'h00, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_SEED, 8'h00, 6'd3, 8'h00, 0, 1'b1);
        add_cmd(lxr_pkg::KIND_SCALED, 8'd255, 6'd63, 8'hff, 0, 1'b0);
        add_cmd(KIND_UNUSED, 8'h00, 6'd0, 8'h00, 0, 1'b0);
        add_cmd(lxr_pkg::KIND_BYTE, 8'h00, 6'd0, 8'h00, 5, 1'b1);

        // random
        for (int i = 0; i < 1450; i++)
        begin
            no_idle = ((i / 120) % 4) == 2;
            g = no_idle ? 0 : pick_gap();
            r = $urandom_range(0, 99);
            if (r < 40)
                k = lxr_pkg::KIND_BYTE;
            else if (r < 75)
                k = lxr_pkg::KIND_SCALED;
            else if (r < 95)
                k = lxr_pkg::KIND_SEED;
            else
                k = KIND_UNUSED;
            add_cmd(k, ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255)
                                                  : 8'($urandom_range(0, 255)),
                    (r < 90) ? 6'($urandom_range(0, TBL_LEN - 1)) : 6'($urandom_range(0, 63)),
                    8'($urandom_range(0, 255)), g, $urandom_range(0, 149) == 0);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || cur_loaded || start)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (2 * TBL_LEN + 10) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_bytes.size());
            err_count++;
        end
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* sim.f */
design/lxr_pkg.sv
design/lxr_mem.sv
design/lagged_xor_byte_rng.sv
tb/sv/lagged_xor_byte_rng_test.sv
